// ===== hdl/npsm_pkg.sv =====
// ---------------------------------------------------------------------------
// npsm_pkg - shared types and constants of the nearest point search block
// Field widths, default sizes, op codes and the controller/datapath bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package npsm_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int GRID_BITS_DEF  = 8;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int OP_W    = 2;
    localparam int COORD_W = 8;
    localparam int QUERY_W = 16;
    localparam int DIST_W  = 17;

    // memo entries carry a generation tag, a clear just moves to the next one
    localparam int EPOCH_BITS = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } npsm_op_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_FULL,
        OUT_MEMO,
        OUT_SCAN
    } npsm_out_t;

    typedef struct packed {
        logic      latch;
        logic      clear;
        logic      add_point;
        logic      memo_wr_add;
        logic      memo_wr_query;
        logic      wipe;
        logic      scan_start;
        logic      sqrt_start;
        logic      out_load;
        npsm_out_t out_kind;
    } npsm_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            table_full;
        logic            count_zero;
        logic            memo_hit;
        logic            epoch_max;
        logic            wipe_done;
        logic            scan_done;
        logic            sqrt_busy;
    } npsm_sts_t;

endpackage

`default_nettype wire

// ===== hdl/npsm_sqrt.sv =====
// ---------------------------------------------------------------------------
// npsm_sqrt - iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle, floor result.
// ---------------------------------------------------------------------------
`default_nettype none

module npsm_sqrt #(
    parameter int VAL_W = 33
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [VAL_W-1:0]       value,
    output logic                        busy,
    output logic [(VAL_W+1)/2-1:0]      root
);

    localparam int RW    = (VAL_W + 1) / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [2*RW-1:0] val_reg, val_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    always_comb begin
        rem_sh    = {rem_reg[RW-1:0], val_reg[2*RW-1 -: 2]};
        trial     = {root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            val_next  = (2*RW)'(value);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RW);
        end else if (cnt_reg != '0) begin
            val_next = {val_reg[2*RW-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/npsm_datapath.sv =====
// ---------------------------------------------------------------------------
// npsm_datapath - point table, cell memo, scan pipeline and result register
// Executes the controller's commands and reports status back to it.
// ---------------------------------------------------------------------------
`default_nettype none

module npsm_datapath #(
    parameter int MAX_POINTS = npsm_pkg::MAX_POINTS_DEF,
    parameter int GRID_BITS  = npsm_pkg::GRID_BITS_DEF,
    parameter int FRAC_BITS  = npsm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire npsm_pkg::npsm_cmd_t           cmd,
    output npsm_pkg::npsm_sts_t                sts,
    input  wire logic [npsm_pkg::OP_W-1:0]     in_op,
    input  wire logic [npsm_pkg::COORD_W-1:0]  in_point_x,
    input  wire logic [npsm_pkg::COORD_W-1:0]  in_point_y,
    input  wire logic [npsm_pkg::QUERY_W-1:0]  in_query_x,
    input  wire logic [npsm_pkg::QUERY_W-1:0]  in_query_y,
    output logic [npsm_pkg::COORD_W-1:0]       near_x,
    output logic [npsm_pkg::COORD_W-1:0]       near_y,
    output logic [npsm_pkg::DIST_W-1:0]        dist_fixed,
    output logic                               found,
    output logic                               from_memo,
    output logic                               table_full
);

    import npsm_pkg::*;

    localparam int PAW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CELL_W = 2 * GRID_BITS;
    localparam int MEMO_DEPTH = 1 << CELL_W;
    localparam int SW = (QUERY_W > COORD_W + FRAC_BITS) ? QUERY_W : COORD_W + FRAC_BITS;
    localparam int DW = (QUERY_W - FRAC_BITS > COORD_W) ? QUERY_W - FRAC_BITS : COORD_W;
    localparam int SQ_W = 2 * DW + 1;
    localparam int VAL_W = SQ_W + 2 * FRAC_BITS;
    localparam int RW = (VAL_W + 1) / 2;
    // memo word: tag | x | y | distance
    localparam int ANS_W = 2 * COORD_W + DIST_W;
    localparam int MW = EPOCH_BITS + ANS_W;

    // latched item
    logic [OP_W-1:0]    op_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [QUERY_W-1:0] qx_reg, qy_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [CELL_W-1:0]     wipe_cnt_reg;

    logic [2*COORD_W-1:0] pt_mem [0:MAX_POINTS-1];
    logic [2*COORD_W-1:0] pt_rd_reg;
    logic [MW-1:0]        memo_mem [0:MEMO_DEPTH-1];
    logic [MW-1:0]        memo_rd_reg;

    logic [CELL_W-1:0] pcell, qcell, memo_raddr, memo_waddr;
    logic              memo_we;
    logic [MW-1:0]     memo_wdata;

    // scan pipeline
    logic             issuing_reg, v1_reg, v2_reg, v3_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [DW-1:0]    adx_reg, ady_reg;
    logic [COORD_W-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    logic [2*DW-1:0]  sqx_reg, sqy_reg;
    logic [SQ_W-1:0]  sq_sum;
    logic             have_reg;
    logic [SQ_W-1:0]  best_reg;
    logic [COORD_W-1:0] bx_reg, by_reg;

    logic [RW-1:0] root;
    logic          sqrt_busy;

    function automatic logic [DW-1:0] cell_dist(input logic [QUERY_W-1:0] q,
                                                input logic [COORD_W-1:0] p);
        logic [SW-1:0] qe;
        logic [SW-1:0] pe;
        logic [SW-1:0] a;
        qe = SW'(q);
        pe = SW'(p) << FRAC_BITS;
        a  = (qe >= pe) ? (qe - pe) : (pe - qe);
        return DW'(a >> FRAC_BITS);
    endfunction

    assign pcell = {GRID_BITS'(px_reg), GRID_BITS'(py_reg)};
    assign qcell = {GRID_BITS'(qx_reg >> FRAC_BITS), GRID_BITS'(qy_reg >> FRAC_BITS)};
    assign memo_raddr = (op_reg == OP_ADD) ? pcell : qcell;

    always_comb begin
        memo_we    = 1'b0;
        memo_waddr = qcell;
        memo_wdata = {epoch_reg, bx_reg, by_reg, DIST_W'(root)};
        if (cmd.wipe) begin
            memo_we    = 1'b1;
            memo_waddr = wipe_cnt_reg;
            memo_wdata = '0;
        end else if (cmd.memo_wr_add) begin
            memo_we    = 1'b1;
            memo_waddr = pcell;
            memo_wdata = {epoch_reg, px_reg, py_reg, {DIST_W{1'b0}}};
        end else if (cmd.memo_wr_query) begin
            memo_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (memo_we) begin
            memo_mem[memo_waddr] <= memo_wdata;
        end
        memo_rd_reg <= memo_mem[memo_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_point) begin
            pt_mem[count_reg[PAW-1:0]] <= {px_reg, py_reg};
        end
        pt_rd_reg <= pt_mem[rd_idx_reg[PAW-1:0]];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            epoch_reg    <= EPOCH_BITS'(1);
            wipe_cnt_reg <= '0;
            issuing_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            have_reg     <= 1'b0;
            rd_idx_reg   <= '0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
                if (epoch_reg != '1) begin
                    epoch_reg <= epoch_reg + 1'b1;
                end
            end else if (cmd.add_point) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.wipe) begin
                wipe_cnt_reg <= wipe_cnt_reg + 1'b1;
                if (wipe_cnt_reg == '1) begin
                    epoch_reg <= EPOCH_BITS'(1);
                end
            end
            if (cmd.scan_start) begin
                issuing_reg <= 1'b1;
                rd_idx_reg  <= '0;
                have_reg    <= 1'b0;
            end else if (issuing_reg) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == CNT_W'(count_reg - 1'b1)) begin
                    issuing_reg <= 1'b0;
                end
            end
            v1_reg <= issuing_reg && !cmd.scan_start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg && (!have_reg || sq_sum < best_reg)) begin
                have_reg <= 1'b1;
            end
        end
    end

    assign sq_sum = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg <= in_op;
            px_reg <= in_point_x;
            py_reg <= in_point_y;
            qx_reg <= in_query_x;
            qy_reg <= in_query_y;
        end
        adx_reg <= cell_dist(qx_reg, pt_rd_reg[2*COORD_W-1:COORD_W]);
        ady_reg <= cell_dist(qy_reg, pt_rd_reg[COORD_W-1:0]);
        s1x_reg <= pt_rd_reg[2*COORD_W-1:COORD_W];
        s1y_reg <= pt_rd_reg[COORD_W-1:0];
        sqx_reg <= adx_reg * adx_reg;
        sqy_reg <= ady_reg * ady_reg;
        s2x_reg <= s1x_reg;
        s2y_reg <= s1y_reg;
        // strict compare keeps the earliest point on ties
        if (v3_reg && (!have_reg || sq_sum < best_reg)) begin
            best_reg <= sq_sum;
            bx_reg   <= s2x_reg;
            by_reg   <= s2y_reg;
        end
        if (cmd.out_load) begin
            near_x     <= '0;
            near_y     <= '0;
            dist_fixed <= '0;
            found      <= 1'b0;
            from_memo  <= 1'b0;
            table_full <= 1'b0;
            case (cmd.out_kind)
                OUT_FULL: begin
                    table_full <= 1'b1;
                end
                OUT_MEMO: begin
                    near_x     <= memo_rd_reg[ANS_W-1 -: COORD_W];
                    near_y     <= memo_rd_reg[DIST_W+COORD_W-1 -: COORD_W];
                    dist_fixed <= memo_rd_reg[DIST_W-1:0];
                    found      <= 1'b1;
                    from_memo  <= 1'b1;
                end
                OUT_SCAN: begin
                    near_x     <= bx_reg;
                    near_y     <= by_reg;
                    dist_fixed <= DIST_W'(root);
                    found      <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    npsm_sqrt #(
        .VAL_W (VAL_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .value   (VAL_W'(best_reg) << (2 * FRAC_BITS)),
        .busy    (sqrt_busy),
        .root    (root)
    );

    always_comb begin
        sts.op         = op_reg;
        sts.table_full = (count_reg == CNT_W'(MAX_POINTS));
        sts.count_zero = (count_reg == '0);
        sts.memo_hit   = (memo_rd_reg[MW-1 -: EPOCH_BITS] == epoch_reg);
        sts.epoch_max  = (epoch_reg == '1);
        sts.wipe_done  = (wipe_cnt_reg == '1);
        sts.scan_done  = !issuing_reg && !v1_reg && !v2_reg && !v3_reg;
        sts.sqrt_busy  = sqrt_busy;
    end

endmodule

`default_nettype wire

// ===== hdl/npsm_ctrl.sv =====
// ---------------------------------------------------------------------------
// npsm_ctrl - sequencer of the nearest point search block
// Decodes each word, steps the datapath and owns both stream handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module npsm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output npsm_pkg::npsm_cmd_t       cmd,
    input  wire npsm_pkg::npsm_sts_t  sts
);

    import npsm_pkg::*;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_CHK,
        ST_Q_CHK,
        ST_SCAN,
        ST_SQRT,
        ST_OUT
    } state_t;

    state_t    state_reg, state_next;
    npsm_out_t kind_reg, kind_next;
    logic      resp_reg, resp_next;
    logic      m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        resp_next  = resp_reg;
        cmd        = '0;
        cmd.out_kind = kind_reg;
        unique case (state_reg)
            ST_WIPE: begin
                cmd.wipe = 1'b1;
                if (sts.wipe_done) begin
                    resp_next  = 1'b0;
                    state_next = resp_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (sts.op)
                    OP_CLEAR: begin
                        cmd.clear = 1'b1;
                        kind_next = OUT_ZERO;
                        // tag space used up: sweep the memo before answering
                        if (sts.epoch_max) begin
                            resp_next  = 1'b1;
                            state_next = ST_WIPE;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                    OP_ADD:   state_next = ST_ADD_CHK;
                    OP_QUERY: state_next = ST_Q_CHK;
                    default: begin
                        kind_next  = OUT_ZERO;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_ADD_CHK: begin
                if (sts.table_full) begin
                    kind_next = OUT_FULL;
                end else begin
                    cmd.add_point   = 1'b1;
                    cmd.memo_wr_add = !sts.memo_hit;
                    kind_next       = OUT_ZERO;
                end
                state_next = ST_OUT;
            end
            ST_Q_CHK: begin
                if (sts.memo_hit) begin
                    kind_next  = OUT_MEMO;
                    state_next = ST_OUT;
                end else if (sts.count_zero) begin
                    kind_next  = OUT_ZERO;
                    state_next = ST_OUT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (!sts.sqrt_busy) begin
                    cmd.memo_wr_query = 1'b1;
                    kind_next         = OUT_SCAN;
                    state_next        = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WIPE;
            kind_reg    <= OUT_ZERO;
            resp_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            resp_reg    <= resp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted word not dispatched");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> !sts.count_zero)
        else $error("scan started on empty table");

    a_wipe_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wipe |-> !s_tready)
        else $error("input open during memo sweep");

    a_sqrt_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |=> sts.sqrt_busy)
        else $error("root unit did not start");

endmodule

`default_nettype wire

// ===== hdl/nearest_point_search_memo.sv =====
// ---------------------------------------------------------------------------
// nearest_point_search_memo - nearest stored grid point with a per-cell memo
//
// Input stream: s_tuser carries the op (clear, add point, query), s_tdata the
// point and query coordinates. One result word comes back on the m_ stream
// for every input word, in order.
// Clears, adds, unused ops, memo hits and queries on an empty table answer
// without a scan. A memo miss scans the N stored points (one table entry per
// cycle from the point memory) and then runs the bit-serial root unit, whose
// result is R bits wide (17 with the default sizes).
// One word is worked on at a time; the next is taken the cycle after the
// result is loaded, even while that result waits for m_tready.
// Memo entries carry a generation tag, so a clear is quick; every 255th clear
// and the pass after reset sweep all 2^(2*GRID_BITS) memo entries
// (65536 by default), with s_tready low.
// A stalled receiver holds m_tdata/m_tuser; a second result waits inside.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_memo #(
    parameter int MAX_POINTS = npsm_pkg::MAX_POINTS_DEF,
    parameter int GRID_BITS  = npsm_pkg::GRID_BITS_DEF,
    parameter int FRAC_BITS  = npsm_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // point_x, point_y, query_x, query_y
    input  wire logic [1:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // near_x, near_y, dist_fixed, zero pad
    output logic [2:0]       m_tuser    // found, from_memo, table_full
);

    import npsm_pkg::*;

    npsm_cmd_t cmd;
    npsm_sts_t sts;

    logic [COORD_W-1:0] near_x, near_y;
    logic [DIST_W-1:0]  dist_fixed;
    logic               found, from_memo, table_full;

    npsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    npsm_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .GRID_BITS  (GRID_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_point_x (s_tdata[7:0]),
        .in_point_y (s_tdata[15:8]),
        .in_query_x (s_tdata[31:16]),
        .in_query_y (s_tdata[47:32]),
        .near_x     (near_x),
        .near_y     (near_y),
        .dist_fixed (dist_fixed),
        .found      (found),
        .from_memo  (from_memo),
        .table_full (table_full)
    );

    assign m_tdata = {7'd0, dist_fixed, near_y, near_x};
    assign m_tuser = {table_full, from_memo, found};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for nearest_point_search_memo
// Drives clear, add, query and unused-op words on the s_ stream with random
// gaps and back-pressure on the m_ stream. A scoreboard keeps its own point
// table and per-cell memo, predicts one answer word per input word and checks
// every result word field by field. Phases cover the directed corner cases,
// random point clusters and a short run of clears.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import npsm_pkg::*;

    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int GRID           = GRID_BITS_DEF;
    localparam int TABLE_CAP      = MAX_POINTS_DEF;
    localparam int CELL_MASK      = (1 << GRID) - 1;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int TAIL_CYCLES    = 40;
    localparam int CLEAR_ROUNDS   = 2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] near_x;
        logic [COORD_W-1:0] near_y;
        logic [DIST_W-1:0]  dist_fixed;
        logic               found;
        logic               from_memo;
        logic               table_full;
    } near_answer_t;

    class nearest_scoreboard;
        logic [2*COORD_W-1:0] point_tab [TABLE_CAP];
        int unsigned          point_cnt;
        near_answer_t         memo_tab [int unsigned];
        near_answer_t         answers_due [$];
        int unsigned          err_count;
        int unsigned          words_checked;

        function new();
            point_cnt     = 0;
            err_count     = 0;
            words_checked = 0;
        endfunction

        function int unsigned cell_of(int unsigned cx, int unsigned cy);
            return ((cx & CELL_MASK) << GRID) | (cy & CELL_MASK);
        endfunction

        // whole cells between a fixed-point coordinate and a cell, toward zero
        function int cell_diff(logic [QUERY_W-1:0] q, logic [COORD_W-1:0] p);
            int q_fix;
            int p_fix;
            q_fix = q;
            p_fix = p;
            p_fix = p_fix << FRAC;
            return (q_fix - p_fix) / (1 << FRAC);
        endfunction

        // floor of the square root, one result bit at a time from the top
        function logic [DIST_W-1:0] fixed_root(longint unsigned v);
            logic [DIST_W-1:0] r;
            longint unsigned   t;
            r = '0;
            for (int b = DIST_W - 1; b >= 0; b--) begin
                t = longint'(r) | (longint'(1) << b);
                if (t * t <= v) r[b] = 1'b1;
            end
            return r;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [COORD_W-1:0] px,
                                logic [COORD_W-1:0] py, logic [QUERY_W-1:0] qx,
                                logic [QUERY_W-1:0] qy);
            near_answer_t ans;
            near_answer_t self_ans;
            int unsigned  cell_idx;
            int           dx;
            int           dy;
            int           sq;
            int           best;
            ans = '0;
            case (op)
                OP_CLEAR: begin
                    point_cnt = 0;
                    memo_tab.delete();
                end
                OP_ADD: begin
                    if (point_cnt < TABLE_CAP) begin
                        point_tab[point_cnt] = {px, py};
                        point_cnt++;
                        cell_idx = cell_of(px, py);
                        // an existing memo entry wins over the new point
                        if (!memo_tab.exists(cell_idx)) begin
                            self_ans           = '0;
                            self_ans.near_x    = px;
                            self_ans.near_y    = py;
                            memo_tab[cell_idx] = self_ans;
                        end
                    end else begin
                        ans.table_full = 1'b1;
                    end
                end
                OP_QUERY: begin
                    cell_idx = cell_of(qx >> FRAC, qy >> FRAC);
                    if (memo_tab.exists(cell_idx)) begin
                        ans            = memo_tab[cell_idx];
                        ans.found      = 1'b1;
                        ans.from_memo  = 1'b1;
                        ans.table_full = 1'b0;
                    end else if (point_cnt != 0) begin
                        best = -1;
                        for (int i = 0; i < point_cnt; i++) begin
                            dx = cell_diff(qx, point_tab[i][15:8]);
                            dy = cell_diff(qy, point_tab[i][7:0]);
                            sq = dx * dx + dy * dy;
                            // strict compare keeps the earliest point on a tie
                            if (best < 0 || sq < best) begin
                                best       = sq;
                                ans.near_x = point_tab[i][15:8];
                                ans.near_y = point_tab[i][7:0];
                            end
                        end
                        ans.dist_fixed     = fixed_root(longint'(best) << (2 * FRAC));
                        ans.found          = 1'b1;
                        memo_tab[cell_idx] = ans;
                    end
                end
                default: ;
            endcase
            answers_due = {answers_due, ans};
        endfunction

        task report_mismatch(string what, logic [39:0] got, logic [39:0] want);
            err_count++;
            $display("mismatch on result word %0d, %s: got %0h, want %0h",
                     words_checked, what, got, want);
        endtask

        task check_word(logic [39:0] tdata, logic [2:0] tuser);
            near_answer_t want;
            words_checked++;
            if (answers_due.size() == 0) begin
                report_mismatch("no word expected", tdata, '0);
                return;
            end
            want = answers_due.pop_front();
            if (tdata[7:0] !== want.near_x)
                report_mismatch("near_x", tdata[7:0], want.near_x);
            if (tdata[15:8] !== want.near_y)
                report_mismatch("near_y", tdata[15:8], want.near_y);
            if (tdata[32:16] !== want.dist_fixed)
                report_mismatch("dist_fixed", tdata[32:16], want.dist_fixed);
            if (tdata[39:33] !== '0)
                report_mismatch("pad bits", tdata[39:33], '0);
            if (tuser[0] !== want.found)
                report_mismatch("found", tuser[0], want.found);
            if (tuser[1] !== want.from_memo)
                report_mismatch("from_memo", tuser[1], want.from_memo);
            if (tuser[2] !== want.table_full)
                report_mismatch("table_full", tuser[2], want.table_full);
        endtask

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // point_x, point_y, query_x, query_y
    logic [1:0]  s_tuser  = '0;    // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // near_x, near_y, dist_fixed, zero pad
    logic [2:0]  m_tuser;          // found, from_memo, table_full

    nearest_scoreboard near_sb;
    bit                idle_on = 1'b1;
    int unsigned       quiet_cycles = 0;
    logic [7:0]        last_px = '0;
    logic [7:0]        last_py = '0;
    logic [15:0]       last_qx = '0;
    logic [15:0]       last_qy = '0;
    logic [7:0]        hot_x = '0;
    logic [7:0]        hot_y = '0;

    nearest_point_search_memo u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // mostly back to back, sometimes a short gap, now and then a long hold; none while idle_on is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            near_sb.note_word(s_tuser, s_tdata[7:0], s_tdata[15:8],
                              s_tdata[31:16], s_tdata[47:32]);
        if (aresetn && m_tvalid && m_tready)
            near_sb.check_word(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] op, input logic [7:0] px,
                             input logic [7:0] py, input logic [15:0] qx,
                             input logic [15:0] qy);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {qy, qx, py, px};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (near_sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // clustered adds and queries so that scans, ties and memo hits all occur
    task automatic random_run(input int n);
        int          r;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [15:0] qx;
        logic [15:0] qy;
        for (int k = 0; k < n; k++) begin
            r  = $urandom_range(0, 99);
            px = 8'($urandom);
            py = 8'($urandom);
            qx = 16'($urandom);
            qy = 16'($urandom);
            if (r < 4) begin
                send_word(OP_CLEAR, px, py, qx, qy);
            end else if (r < 8) begin
                send_word(OP_UNUSED, px, py, qx, qy);
            end else if (r < 45) begin
                if ($urandom_range(0, 3) != 0) begin
                    px = hot_x + 8'($urandom_range(0, 8)) - 8'd4;
                    py = hot_y + 8'($urandom_range(0, 8)) - 8'd4;
                end
                last_px = px;
                last_py = py;
                send_word(OP_ADD, px, py, qx, qy);
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        qx = last_qx;
                        qy = last_qy;
                    end
                    1: begin
                        qx[15:8] = last_px;
                        qy[15:8] = last_py;
                    end
                    2, 3: begin
                        qx[15:8] = hot_x + 8'($urandom_range(0, 16)) - 8'd8;
                        qy[15:8] = hot_y + 8'($urandom_range(0, 16)) - 8'd8;
                    end
                    default: ;
                endcase
                last_qx = qx;
                last_qy = qy;
                send_word(OP_QUERY, px, py, qx, qy);
            end
        end
    endtask

    initial begin
        near_sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, unused op, corners of the grid
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_word(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_ADD, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
        send_word(OP_ADD, 8'hFF, 8'hFF, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 8'hFF, 8'hFF, 16'h00FF, 16'h0080);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
        // both corners equally far, the first one stored wins
        send_word(OP_QUERY, 8'h00, 8'h00, 16'hFF00, 16'h0000);
        send_word(OP_QUERY, 8'hA5, 8'h5A, 16'hFF7F, 16'h00C0);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h80FF, 16'h7F01);
        send_word(OP_ADD, 8'h0A, 8'h0A, 16'h0000, 16'h0000);
        send_word(OP_ADD, 8'h0C, 8'h0A, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h0B00, 16'h0A00);
        // negative fraction truncates toward zero
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h0BFF, 16'h0B80);
        // memoized miss, then an add on that cell keeps the older answer
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h1410, 16'h1420);
        send_word(OP_ADD, 8'h14, 8'h14, 16'hFFFF, 16'h0000);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h14FF, 16'h14FF);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h1480, 16'h1381);
        // largest possible distance
        send_word(OP_CLEAR, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_ADD, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
        send_word(OP_CLEAR, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 8'h00, 8'h00, 16'h1234, 16'h5678);
        send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        drain_results();

        hot_x = 8'($urandom);
        hot_y = 8'($urandom);
        random_run(40);
        idle_on = 1'b0;
        hot_x   = 8'($urandom);
        random_run(30);
        idle_on = 1'b1;
        drain_results();
        hot_y = 8'($urandom);
        random_run(40);

        // clears in a row, each must hide the memo of the round before
        for (int k = 0; k < CLEAR_ROUNDS; k++) begin
            send_word(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom));
            send_word(OP_ADD, 8'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom));
            send_word(OP_QUERY, 8'($urandom), 8'($urandom), {8'h40, 8'($urandom)},
                      {8'h40, 8'($urandom)});
            if (k % 4 == 0)
                send_word(OP_QUERY, 8'($urandom), 8'($urandom),
                          {8'h40, 8'($urandom)}, {8'h40, 8'($urandom)});
        end

        s_tvalid <= 1'b0;
        while (near_sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (near_sb.err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== nearest_point_search_memo.f =====
hdl/npsm_pkg.sv
hdl/npsm_sqrt.sv
hdl/npsm_datapath.sv
hdl/npsm_ctrl.sv
hdl/nearest_point_search_memo.sv
tb/tb_top.sv
